// ===== sv/wrpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Wind/rain pulse tracker package
// Shared widths, constants, register indexes and transfer types.
// ----------------------------------------------------------------------------
package wrpg_pkg;

  localparam int GUST_SLOTS = 30;
  localparam int PULSE_W    = 16;

  localparam int SLOT_W = $clog2(GUST_SLOTS);
  localparam int SCAN_W = $clog2(GUST_SLOTS + 1);

  localparam int TIME_W     = 32;
  localparam int DEBOUNCE_W = 20;
  localparam int FACTOR_W   = 16;
  localparam int TIP_W      = 8;
  localparam int SPEED_W    = 20;
  localparam int RAIN_W     = 32;

  localparam int PROD_W    = PULSE_W + FACTOR_W;
  localparam int TIPPROD_W = PULSE_W + TIP_W;

  // Division by 1000 is done as x * (2^32 + RECIP_LO) >> 42, which is exact
  // for every product below 2^32.
  localparam int            RECIP_W    = 27;
  localparam logic [26:0]   RECIP_LO   = 27'd103079216;
  localparam int            RECIP_HI   = 32;
  localparam int            QUOT_SHIFT = 10;
  localparam int            QUOT_W     = PROD_W + 1 - QUOT_SHIFT;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic [RAIN_W-1:0]  RAIN_MAX  = '1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DEBOUNCE_W;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 20'd15000;
  localparam logic [FACTOR_W-1:0]   FACTOR_RST   = 16'd14920;
  localparam logic [TIP_W-1:0]      TIP_RST      = 8'd11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE     = 2'd0,
    CFG_SPEED_FACTOR = 2'd1,
    CFG_RAIN_PER_TIP = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_MUL,
    ST_SCALE,
    ST_QUOT,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] now_us;
    logic              rain_edge;
    logic              wind_edge;
    logic              interval_tick;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] wind_speed;
    logic [SPEED_W-1:0] gust_max;
    logic [RAIN_W-1:0]  rain_total;
    logic               interval_done;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic clear;
  } chan_ctl_t;

  typedef struct packed {
    logic               start;
    logic [SLOT_W-1:0]  slot;
    logic [SPEED_W-1:0] speed;
  } gust_cmd_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SPEED_W-1:0] gust_max;
  } gust_sts_t;

endpackage

// ===== sv/wind_rain_pulse_gust_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Wind and rain pulse tracker
// Debounced anemometer and rain gauge counters with a gust ring maximum.
// ----------------------------------------------------------------------------
// Each accepted item returns one result. An item without an interval tick
// passes through the edge update and the done state until its result is
// loaded into the output register, and the next item can be accepted once
// the core is back in its idle state. An item with a tick passes through
// edge update, multiply, scale, quotient and ring write, then a scan of the
// gust ring that reads one slot per cycle through the single read port of
// its memory, then the close of the scan and the load of the result.
// A result that finds the output register still full waits until it is taken.
// The output register lets a new item in while an earlier result still waits
// to be taken.
module wind_rain_pulse_gust_tracker_core
  import wrpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [FACTOR_W-1:0]   factor_q;
  logic [TIP_W-1:0]      tip_q;

  in_item_t                    item_q;
  logic [PROD_W-1:0]           prod_q;
  logic [TIPPROD_W-1:0]        rain_prod_q;
  logic [PROD_W+RECIP_W-1:0]   scale_q;
  logic [SPEED_W-1:0]          last_speed_q;
  logic [SLOT_W-1:0]           slot_q;
  logic [RAIN_W-1:0]           rain_sum_q;
  logic                        out_valid_q;
  out_item_t                   out_q;

  logic               accept;
  logic               edge_step;
  logic               clear_cnt;
  logic               load_out;
  logic               out_free;
  logic [PULSE_W-1:0] rain_cnt;
  logic [PULSE_W-1:0] wind_cnt;
  logic [PROD_W:0]    quot_sum;
  logic [QUOT_W-1:0]  quot;
  logic [RAIN_W:0]    rain_next;

  chan_ctl_t rain_ctl, wind_ctl;
  gust_cmd_t gust_cmd;
  gust_sts_t gust_sts;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      factor_q   <= FACTOR_RST;
      tip_q      <= TIP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE:     debounce_q <= cfg_data_i;
        CFG_SPEED_FACTOR: factor_q   <= cfg_data_i[FACTOR_W-1:0];
        CFG_RAIN_PER_TIP: tip_q      <= cfg_data_i[TIP_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d        = state_q;
    edge_step      = 1'b0;
    clear_cnt      = 1'b0;
    load_out       = 1'b0;
    gust_cmd.start = 1'b0;
    gust_cmd.slot  = slot_q;
    gust_cmd.speed = last_speed_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EDGE;
      end
      ST_EDGE: begin
        edge_step = 1'b1;
        state_d   = item_q.interval_tick ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        clear_cnt = 1'b1;
        state_d   = ST_SCALE;
      end
      ST_SCALE: state_d = ST_QUOT;
      ST_QUOT:  state_d = ST_WRITE;
      ST_WRITE: begin
        gust_cmd.start = 1'b1;
        state_d        = ST_SCAN;
      end
      ST_SCAN: begin
        if (gust_sts.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign rain_ctl.take  = edge_step && item_q.rain_edge;
  assign rain_ctl.clear = clear_cnt;
  assign wind_ctl.take  = edge_step && item_q.wind_edge;
  assign wind_ctl.clear = clear_cnt;

  wrpg_chan u_rain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (rain_ctl),
    .now_us_i      (item_q.now_us),
    .debounce_us_i (debounce_q),
    .count_o       (rain_cnt)
  );

  wrpg_chan u_wind (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (wind_ctl),
    .now_us_i      (item_q.now_us),
    .debounce_us_i (debounce_q),
    .count_o       (wind_cnt)
  );

  // floor(p / 1000) = (p + ((p * RECIP_LO) >> 32)) >> 10
  assign quot_sum  = {1'b0, prod_q} + (PROD_W+1)'(scale_q[PROD_W+RECIP_W-1:RECIP_HI]);
  assign quot      = quot_sum[PROD_W:QUOT_SHIFT];
  assign rain_next = {1'b0, rain_sum_q} + (RAIN_W+1)'(rain_prod_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_MUL) begin
      prod_q      <= wind_cnt * factor_q;
      rain_prod_q <= rain_cnt * tip_q;
    end
    if (state_q == ST_SCALE) begin
      scale_q <= prod_q * RECIP_LO;
    end
    if (load_out) begin
      out_q.wind_speed    <= last_speed_q;
      out_q.gust_max      <= gust_sts.gust_max;
      out_q.rain_total    <= rain_sum_q;
      out_q.interval_done <= item_q.interval_tick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_speed_q <= '0;
      slot_q       <= '0;
      rain_sum_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == ST_SCALE) begin
        rain_sum_q <= rain_next[RAIN_W] ? RAIN_MAX : rain_next[RAIN_W-1:0];
      end
      if (state_q == ST_QUOT) begin
        last_speed_q <= (quot > QUOT_W'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
        slot_q       <= (slot_q == SLOT_W'(GUST_SLOTS - 1)) ? '0 : slot_q + SLOT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  wrpg_gust u_gust (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (gust_cmd),
    .sts_o  (gust_sts)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gust_cmd.start |-> !gust_sts.busy)
    else $error("gust scan started while a scan is running");

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gust_sts.done |-> state_q == ST_SCAN)
    else $error("gust scan finished outside the scan state");

  a_rain_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> rain_sum_q >= $past(rain_sum_q))
    else $error("rain total decreased");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result presented without finishing an item");
`endif

endmodule

// ===== sv/wrpg_chan.sv =====
// ----------------------------------------------------------------------------
// Pulse channel
// Debounces time-stamped edges and keeps a saturating pulse count.
// ----------------------------------------------------------------------------
module wrpg_chan
  import wrpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  chan_ctl_t             ctl_i,
  input  logic [TIME_W-1:0]     now_us_i,
  input  logic [DEBOUNCE_W-1:0] debounce_us_i,
  output logic [PULSE_W-1:0]    count_o
);

  logic [PULSE_W-1:0] count_q, count_d;
  logic [TIME_W-1:0]  last_q, last_d;
  logic [TIME_W-1:0]  delta;
  logic               pass;

  // A negative wrapped difference means the timestamp went backwards.
  assign delta = now_us_i - last_q;
  assign pass  = !delta[TIME_W-1] && (delta >= TIME_W'(debounce_us_i));

  always_comb begin
    count_d = count_q;
    last_d  = last_q;
    if (ctl_i.clear) begin
      count_d = '0;
    end else if (ctl_i.take && pass) begin
      last_d = now_us_i;
      if (count_q != '1) begin
        count_d = count_q + PULSE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      last_q  <= '0;
    end else begin
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  assign count_o = count_q;

endmodule

// ===== sv/wrpg_gust.sv =====
// ----------------------------------------------------------------------------
// Gust ring
// Ring of recent interval speeds in a synchronous memory, with a maximum scan.
// ----------------------------------------------------------------------------
module wrpg_gust
  import wrpg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gust_cmd_t cmd_i,
  output gust_sts_t sts_o
);

  logic [SPEED_W-1:0]    mem [GUST_SLOTS];
  logic [GUST_SLOTS-1:0] valid_q;
  logic [SPEED_W-1:0]    rd_data_q;
  logic [SLOT_W-1:0]     rd_idx_q;
  logic                  rd_vld_q;
  logic                  busy_q;
  logic                  done_q;
  logic [SCAN_W-1:0]     cnt_q;
  logic [SPEED_W-1:0]    max_q, max_d;
  logic                  rd_en;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SPEED_W-1:0]    entry;

  assign rd_en   = busy_q && (cnt_q < SCAN_W'(GUST_SLOTS));
  assign rd_addr = cnt_q[SLOT_W-1:0];

  // The new speed is written in the cycle before the scan reads its first slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mem[cmd_i.slot] <= cmd_i.speed;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Slots never written since reset read as zero.
  assign entry = valid_q[rd_idx_q] ? rd_data_q : '0;

  always_comb begin
    max_d = max_q;
    if (cmd_i.start) begin
      max_d = '0;
    end else if (rd_vld_q && (entry > max_q)) begin
      max_d = entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      max_q    <= '0;
    end else begin
      max_q    <= max_d;
      rd_vld_q <= rd_en;
      done_q   <= busy_q && !rd_en;
      if (rd_en) begin
        rd_idx_q <= rd_addr;
      end
      if (cmd_i.start) begin
        valid_q[cmd_i.slot] <= 1'b1;
        busy_q              <= 1'b1;
        cnt_q               <= '0;
      end else if (busy_q) begin
        if (rd_en) begin
          cnt_q <= cnt_q + SCAN_W'(1);
        end else begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign sts_o.busy     = busy_q;
  assign sts_o.done     = done_q;
  assign sts_o.gust_max = max_q;

endmodule
